[design/cia_pkg.sv]
// Shared types and constants for the checked integer ALU.
// No dependencies.
`default_nettype none
package cia_pkg;
	typedef enum logic [2:0] {
		OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
		OP_EQ = 3'd4, OP_LT = 3'd5, OP_GT = 3'd6, OP_AND = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0, ERR_ADD = 3'd1, ERR_SUB = 3'd2, ERR_MUL = 3'd3,
		ERR_DIV = 3'd4, ERR_I32 = 3'd5
	} err_t;

	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S32_MIN = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] S32_MAX = 64'h0000_0000_7FFF_FFFF;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [63:0] lhs;
		logic signed [63:0] rhs;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [2:0]         error_code;
	} out_item_t;

	// classified item between front and back
	typedef struct packed {
		op_t         op;
		logic        narrow;
		logic [63:0] a;
		logic [63:0] b;
		logic        neg;
		logic        arith;
		logic        div_bad;
	} work_t;
endpackage
`default_nettype wire

[design/cia_front.sv]
// Front end: accepts items, narrows operands and classifies them.
// Depends on cia_pkg.
`default_nettype none
module cia_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              narrow_mode,
	input  wire              in_valid,
	output logic             in_ready,
	input  cia_pkg::in_item_t in_data,
	output logic             w_valid,
	input  wire              w_ready,
	output cia_pkg::work_t   w_data
);
	import cia_pkg::*;
	logic   [63:0] a, b;
	work_t  nxt;
	logic   full_q;
	work_t  data_q;

	always_comb begin
		a = narrow_mode ? {{32{in_data.lhs[31]}}, in_data.lhs[31:0]} : in_data.lhs;
		b = narrow_mode ? {{32{in_data.rhs[31]}}, in_data.rhs[31:0]} : in_data.rhs;
		nxt.op      = op_t'(in_data.op);
		nxt.narrow  = narrow_mode;
		nxt.a       = a;
		nxt.b       = b;
		nxt.neg     = a[63] ^ b[63];
		nxt.arith   = !in_data.op[2];
		nxt.div_bad = (b == '0) || (a == S64_MIN && b == '1);
	end

	assign in_ready = !full_q || w_ready;
	assign w_valid  = full_q;
	assign w_data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ready) begin
			full_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end
endmodule
`default_nettype wire

[design/cia_queue.sv]
// Two-entry queue between front and back ends.
// Depends on cia_pkg.
`default_nettype none
module cia_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            i_valid,
	output logic           i_ready,
	input  cia_pkg::work_t i_data,
	output logic           o_valid,
	input  wire            o_ready,
	output cia_pkg::work_t o_data
);
	import cia_pkg::*;
	work_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign i_ready = cnt_q != 2'd2;
	assign o_valid = cnt_q != 2'd0;
	assign o_data  = mem_q[rp_q];
	assign push    = i_valid && i_ready;
	assign pop     = o_valid && o_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= i_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wp_q == rp_q))
		else $error("empty queue with pointers apart");
endmodule
`default_nettype wire

[design/cia_back.sv]
// Back end: single-stage execute (mul in 32x32 partials, radix-2 div) with output register.
// Depends on cia_pkg.
`default_nettype none
module cia_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               w_valid,
	output logic              w_ready,
	input  cia_pkg::work_t    w_data,
	output logic              out_valid,
	input  wire               out_ready,
	output cia_pkg::out_item_t out_data
);
	import cia_pkg::*;
	// Divide iterates one quotient bit per cycle; others finish in the pipe.
	logic        v_s1;
	work_t       d_s1;
	logic [63:0] ma_s1, mb_s1;
	logic [63:0] p_ll_s1, p_lh_s1, p_hl_s1;
	logic        hh_nz_s1;
	logic [63:0] sum_s1, dif_s1;

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic [63:0] rem_q, quo_q, den_q;

	logic        ov_q;
	out_item_t   res_q;

	logic        adv, s1_take, s1_done;
	logic [63:0] ma, mb;
	out_item_t   fin;

	assign ma = w_data.a[63] ? (64'd0 - w_data.a) : w_data.a;
	assign mb = w_data.b[63] ? (64'd0 - w_data.b) : w_data.b;

	// output register frees when empty or taken
	assign adv     = !ov_q || out_ready;
	assign s1_done = v_s1 && !(d_s1.op == OP_DIV && !d_s1.div_bad && (!busy_q || cnt_q != 7'd0));
	assign s1_take = !v_s1 || (s1_done && adv);
	assign w_ready = s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (s1_take) begin
				v_s1   <= w_valid;
				busy_q <= 1'b0;
			end else if (v_s1 && d_s1.op == OP_DIV && !d_s1.div_bad) begin
				if (!busy_q) begin
					busy_q <= 1'b1;
				end
			end
			if (adv) ov_q <= s1_done;
		end
	end

	logic [64:0] trial;
	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (s1_take && w_valid) begin
			d_s1     <= w_data;
			ma_s1    <= ma;
			mb_s1    <= mb;
			p_ll_s1  <= {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
			p_lh_s1  <= {32'd0, ma[31:0]} * {32'd0, mb[63:32]};
			p_hl_s1  <= {32'd0, ma[63:32]} * {32'd0, mb[31:0]};
			hh_nz_s1 <= (ma[63:32] != '0) && (mb[63:32] != '0);
			sum_s1   <= w_data.a + w_data.b;
			dif_s1   <= w_data.a - w_data.b;
		end else if (v_s1 && d_s1.op == OP_DIV && !d_s1.div_bad) begin
			if (!busy_q) begin
				cnt_q <= 7'd64;
				rem_q <= '0;
				quo_q <= ma_s1;
				den_q <= mb_s1;
			end else if (cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[62:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
		end
		if (adv && s1_done) res_q <= fin;
	end

	// finishing logic on stage 1
	logic [65:0] mid;
	logic [63:0] prod, val, lim;
	logic        mbig;
	err_t        err;
	always_comb begin
		mid  = {2'b0, p_lh_s1} + {2'b0, p_hl_s1} + {34'd0, p_ll_s1[63:32]};
		prod = {mid[31:0], p_ll_s1[31:0]};
		mbig = hh_nz_s1 || (mid[65:32] != '0);
		lim  = d_s1.neg ? S64_MIN : S64_MAX;
		val  = '0;
		err  = ERR_OK;
		unique case (d_s1.op)
			OP_ADD: begin
				val = sum_s1;
				if (d_s1.a[63] == d_s1.b[63] && sum_s1[63] != d_s1.a[63]) err = ERR_ADD;
			end
			OP_SUB: begin
				val = dif_s1;
				if (d_s1.a[63] != d_s1.b[63] && dif_s1[63] != d_s1.a[63]) err = ERR_SUB;
			end
			OP_MUL: begin
				if (mbig || prod > lim) err = ERR_MUL;
				val = d_s1.neg ? (64'd0 - prod) : prod;
			end
			OP_DIV: begin
				if (d_s1.div_bad) err = ERR_DIV;
				val = d_s1.neg ? (64'd0 - quo_q) : quo_q;
			end
			OP_EQ:  val = {63'd0, d_s1.a == d_s1.b};
			OP_LT:  val = {63'd0, $signed(d_s1.a) < $signed(d_s1.b)};
			OP_GT:  val = {63'd0, $signed(d_s1.b) < $signed(d_s1.a)};
			default: val = {63'd0, d_s1.a != '0 && d_s1.b != '0};
		endcase
		if (d_s1.arith && err == ERR_OK && d_s1.narrow
			&& val != {{32{val[31]}}, val[31:0]}) err = ERR_I32;
		fin.value      = (err != ERR_OK) ? '0 : val;
		fin.error_code = err;
	end

	assign out_valid = ov_q;
	assign out_data  = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (v_s1 && d_s1.op == OP_DIV))
		else $error("divider busy without a divide");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.error_code != ERR_OK) |-> out_data.value == '0)
		else $error("error result with nonzero value");
endmodule
`default_nettype wire

[design/checked_integer_alu.sv]
// Top level of the checked integer ALU: front end, queue, back end, mode register.
// Depends on cia_pkg, cia_front, cia_queue, cia_back.
// Path: front register, two-entry queue, back-end stage 1 and output register.
// Throughput: one item per cycle while out_ready is high; a divide holds the
// back end while its 64-step restoring divider runs one quotient bit per cycle.
// Reset: asynchronous, clears all valid flags and narrow_mode to 64-bit mode.
`default_nettype none
module checked_integer_alu (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire                cfg_data,
	input  wire                in_valid,
	output logic               in_ready,
	input  cia_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output cia_pkg::out_item_t out_data
);
	import cia_pkg::*;
	logic  narrow_q;
	logic  f_valid, f_ready, q_valid, q_ready;
	work_t f_data, q_data;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			narrow_q <= 1'b0;
		end else if (cfg_valid) begin
			narrow_q <= cfg_data;
		end
	end

	cia_front u_front (.clk, .arst_n, .narrow_mode(narrow_q), .in_valid, .in_ready,
		.in_data, .w_valid(f_valid), .w_ready(f_ready), .w_data(f_data));
	cia_queue u_queue (.clk, .arst_n, .i_valid(f_valid), .i_ready(f_ready),
		.i_data(f_data), .o_valid(q_valid), .o_ready(q_ready), .o_data(q_data));
	cia_back u_back (.clk, .arst_n, .w_valid(q_valid), .w_ready(q_ready),
		.w_data(q_data), .out_valid, .out_ready, .out_data);
endmodule
`default_nettype wire
